>>> sv/cmwc_pkg.sv
package cmwc_pkg;

  // One table word.
  typedef logic [31:0] word_t;

  // Carry and multiplier width.
  localparam int CARRY_W = 15;
  // Width of the product of the multiplier and one table word.
  localparam int PROD_W = 47;

  typedef logic [CARRY_W-1:0] carry_t;
  typedef logic [PROD_W-1:0]  prod_t;

  // Item modes carried in the input tuser bit.
  typedef enum logic {
    MODE_DRAW   = 1'b0,
    MODE_RESEED = 1'b1
  } mode_t;

  // Golden-ratio constant used by the table fill.
  localparam word_t GOLDEN = 32'h9E37_79B9;
  // Lag multiplier.
  localparam carry_t MULT = 15'd18705;
  // Complement base for the returned word.
  localparam word_t COMPL = 32'hFFFF_FFFE;

endpackage

>>> sv/cmwc_lag4096_random_generator_top.sv
// Draw item: one item is in work at a time; the table read, the registered multiply and
// the write-back (which stalls until the output register is free) run in that order, and
// the result is registered with the write-back. The table has one write and one read port.
// Reseed item: one table word is written per cycle; the result is registered after the
// fill, once the output register is free.
// Reset clears the handshake, carry, position and initial_carry; table is undefined.
module cmwc_lag4096_random_generator_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        initial_carry_wr,
  input  logic [14:0] initial_carry_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] value
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]           state;
  cmwc_pkg::carry_t     initial_carry;
  cmwc_pkg::carry_t     carry;
  logic [ADDR_W-1:0]    position;
  logic [ADDR_W-1:0]    pos_inc;
  logic [ADDR_W-1:0]    fill_idx;
  cmwc_pkg::word_t      win_a;
  cmwc_pkg::word_t      win_b;
  cmwc_pkg::word_t      win_c;
  cmwc_pkg::word_t      golden_idx;
  cmwc_pkg::prod_t      prod;
  cmwc_pkg::prod_t      t_sum;
  cmwc_pkg::word_t      draw_word;
  cmwc_pkg::word_t      rd_data;
  cmwc_pkg::word_t      wr_data;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_en;
  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;

  // Handshake and next position.
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign pos_inc       = (position == LAST_IDX) ? '0 : position + 1'b1;

  // Multiply-add result and the complemented word.
  assign t_sum     = prod + cmwc_pkg::PROD_W'(carry);
  assign draw_word = cmwc_pkg::COMPL - t_sum[31:0];

  // Memory write: fill words during a reseed, the new word at the end of a draw.
  assign out_load = ((state == S_WRITE) || (state == S_FIN)) && out_free;
  assign wr_en    = (state == S_FILL) || ((state == S_WRITE) && out_free);
  assign wr_addr  = (state == S_FILL) ? fill_idx : position;
  assign wr_data  = (state == S_FILL) ? win_a : draw_word;

  cmwc_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (pos_inc),
    .rd_data (rd_data)
  );

  // Sequencer for draws and the reseed fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      carry         <= '0;
      position      <= '0;
      initial_carry <= '0;
    end else begin
      if (initial_carry_wr) begin
        initial_carry <= initial_carry_data;
      end
      // A new result takes the output register; otherwise a taken item frees it.
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (s_axis_tuser == cmwc_pkg::MODE_RESEED) begin
              win_a      <= s_axis_tdata + cmwc_pkg::GOLDEN;
              win_b      <= s_axis_tdata + 32'(2 * cmwc_pkg::GOLDEN);
              win_c      <= s_axis_tdata + 32'(3 * cmwc_pkg::GOLDEN);
              golden_idx <= cmwc_pkg::GOLDEN + 32'd3;
              fill_idx   <= '0;
              state      <= S_FILL;
            end else begin
              position <= pos_inc;
              state    <= S_READ;
            end
          end
        end
        S_READ: begin
          prod  <= cmwc_pkg::PROD_W'(cmwc_pkg::MULT) * cmwc_pkg::PROD_W'(rd_data);
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            carry        <= t_sum[cmwc_pkg::PROD_W-1:32];
            m_axis_tdata <= draw_word;
            state        <= S_IDLE;
          end
        end
        S_FILL: begin
          // Window slides by one: the new word is Q[i] + Q[i+1] + GOLDEN + i + 3.
          win_a      <= win_b;
          win_b      <= win_c;
          win_c      <= win_a + win_b + golden_idx;
          golden_idx <= golden_idx + 32'd1;
          fill_idx   <= fill_idx + 1'b1;
          if (fill_idx == LAST_IDX) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            carry        <= initial_carry;
            position     <= '0;
            m_axis_tdata <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted item always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  // The table is written only while filling or finishing a draw.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_FILL) || (state == S_WRITE)))
    else $error("table write outside fill or draw write-back");

  // A result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending item");

  // A draw keeps its position from the read through the write-back.
  a_draw_pos_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(position))
    else $error("position changed during a draw");
`endif

endmodule

>>> sv/cmwc_ram.sv
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
